// ===== rtl/core/gdo_pkg.sv =====
// gregorian date offset: shared types, constants and calendar functions
// no dependencies; used by the interfaces and every module of the block
package gdo_pkg;

  // calendar constants
  localparam int unsigned YearMin       = 1;
  localparam int unsigned YearMax       = 9999;
  localparam int unsigned YearCycle     = 400;
  localparam int unsigned CenturyYears  = 100;
  localparam int unsigned MonthsPerYear = 12;

  localparam int unsigned YearBits  = 14;
  localparam int unsigned MonthBits = 4;
  localparam int unsigned DayBits   = 5;
  localparam int unsigned OffBits   = 16;
  localparam int unsigned StsBits   = 2;
  // bits of a year taken modulo the 400-year cycle
  localparam int unsigned CycBits   = 9;

  // month codes; January and December are used by the walk and the start check
  localparam logic [MonthBits-1:0] MonthJan = 4'd1;
  localparam logic [MonthBits-1:0] MonthFeb = 4'd2;
  localparam logic [MonthBits-1:0] MonthDec = 4'd12;

  // result status codes
  localparam logic [StsBits-1:0] StatusOk       = 2'd0;
  localparam logic [StsBits-1:0] StatusBadStart = 2'd1;
  localparam logic [StsBits-1:0] StatusRange    = 2'd2;

  // request payload
  typedef struct packed {
    logic                 cmd;
    logic [YearBits-1:0]  start_year;
    logic [MonthBits-1:0] start_month;
    logic [DayBits-1:0]   start_day;
    logic [OffBits-1:0]   offset_days;
  } gdo_req_t;

  // result payload
  typedef struct packed {
    logic [YearBits-1:0]  result_year;
    logic [MonthBits-1:0] result_month;
    logic [DayBits-1:0]   result_day;
    logic [StsBits-1:0]   status;
  } gdo_rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic reduce;
    logic check;
    logic walk;
    logic publish;
  } gdo_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic reduce_last;
    logic start_bad;
    logic walk_end;
    logic out_free;
  } gdo_sts_t;

  // leap rule on a year already reduced modulo 400
  function automatic logic is_leap(input logic [CycBits-1:0] r);
    logic century;
    begin
      century = (r == CycBits'(0)) || (r == CycBits'(CenturyYears)) ||
                (r == CycBits'(2 * CenturyYears)) || (r == CycBits'(3 * CenturyYears));
      is_leap = ((r[1:0] == 2'b00) && !century) || (r == CycBits'(0));
    end
  endfunction

  // month length; codes outside 1..12 are flagged by the start check
  function automatic logic [DayBits-1:0] month_days(input logic                 leap,
                                                    input logic [MonthBits-1:0] m);
    begin
      unique case (m)
        4'd2:                    month_days = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
        default:                 month_days = 5'd31;
      endcase
    end
  endfunction

endpackage

// ===== rtl/core/gdo_req_if.sv =====
// gregorian date offset: request channel, valid/ready with a date request
// depends on gdo_pkg
interface gdo_req_if import gdo_pkg::*; ();
  logic     valid;
  logic     ready;
  gdo_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gdo_rsp_if.sv =====
// gregorian date offset: result channel, valid/ready with a result date
// depends on gdo_pkg
interface gdo_rsp_if import gdo_pkg::*; ();
  logic     valid;
  logic     ready;
  gdo_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gregorian_date_offset.sv =====
// gregorian date offset: top level joining controller and datapath
// depends on gdo_pkg, gdo_req_if, gdo_rsp_if, gdo_ctrl, gdo_dp
//
//  channel  dir  payload                                               handshake
//  req_i    in   cmd, start_year, start_month, start_day, offset_days  valid/ready
//  rsp_o    out  result_year, result_month, result_day, status         valid/ready
//
// one request at a time: accept, reduce the year modulo 400 by shifted subtraction,
// check the start date, walk month by month until the day lies in the month or the
// year range ends, then move the result into the output register
// a finished result waits in the output register while the next request is taken
// rsp_o stalls hold the result; a second result waits in the datapath until
// the output register frees; reset clears the state machine and output valid
module gregorian_date_offset import gdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdo_req_if.sink   req_i,
  gdo_rsp_if.source rsp_o
);

  gdo_cmd_t cmd;
  gdo_sts_t sts;

  gdo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gdo_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp_o.data)
  );

endmodule

// ===== rtl/core/gdo_ctrl.sv =====
// gregorian date offset: controller state machine
// depends on gdo_pkg; drives gdo_dp through command and status structs
module gdo_ctrl import gdo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  gdo_sts_t sts_i,
  output gdo_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.reduce_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.start_bad ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/gdo_dp.sv =====
// gregorian date offset: datapath with year reduction, month walk and output register
// depends on gdo_pkg; sequenced by gdo_ctrl
module gdo_dp import gdo_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gdo_req_t req_i,
  input  gdo_cmd_t cmd_i,
  output gdo_sts_t sts_o,
  input  logic     rsp_ready_i,
  output logic     rsp_valid_o,
  output gdo_rsp_t rsp_o
);

  // day counter holds start day plus or minus the offset, with a sign bit
  localparam int unsigned DW = OFFSET_BITS + 2;
  localparam int unsigned NB = (OFFSET_BITS < OffBits) ? OFFSET_BITS : OffBits;
  localparam int unsigned ShBits = 3;
  localparam logic [ShBits-1:0] ShStart = 3'd5;

  logic                  cmd_q;
  logic [YearBits-1:0]   y0_q, y_q;
  logic [MonthBits-1:0]  m0_q, m_q;
  logic [DayBits-1:0]    d0_q;
  logic signed [DW-1:0]  d_q;
  logic [YearBits-1:0]   r_q;
  logic [ShBits-1:0]     sh_q;
  logic [StsBits-1:0]    status_q;
  logic                  out_valid_q;
  gdo_rsp_t              out_q;

  logic [NB-1:0]         off_n;
  logic [YearBits-1:0]   cand;
  logic [CycBits-1:0]    r9, r_next, r_prev, r_back;
  logic [MonthBits-1:0]  m_prev;
  logic [DayBits-1:0]    len_cur, len_prev;
  logic signed [DW-1:0]  len_cur_s, len_prev_s;
  logic                  start_bad, fwd_done, bwd_done, walk_err;

  assign off_n = req_i.offset_days[NB-1:0];
  assign cand  = YearBits'(YearCycle) << sh_q;
  assign r9    = r_q[CycBits-1:0];

  // year neighbors within the 400-year cycle
  assign r_next = (r9 == CycBits'(YearCycle - 1)) ? '0 : r9 + CycBits'(1);
  assign r_prev = (r9 == '0) ? CycBits'(YearCycle - 1) : r9 - CycBits'(1);

  // current month length and the length of the month before
  assign m_prev     = (m_q == MonthJan) ? MonthDec : m_q - MonthBits'(1);
  assign r_back     = (m_q == MonthJan) ? r_prev : r9;
  assign len_cur    = month_days(is_leap(r9), m_q);
  assign len_prev   = month_days(is_leap(r_back), m_prev);
  assign len_cur_s  = $signed({{(DW - DayBits){1'b0}}, len_cur});
  assign len_prev_s = $signed({{(DW - DayBits){1'b0}}, len_prev});

  // start date check
  assign start_bad = (y_q < YearBits'(YearMin)) || (y_q > YearBits'(YearMax)) ||
                     (m_q < MonthJan) || (m_q > MonthDec) ||
                     (d0_q == '0) || (d0_q > len_cur);

  // walk end and range error
  assign fwd_done = (d_q <= len_cur_s);
  assign bwd_done = (d_q > $signed(DW'(0)));
  assign walk_err = cmd_q ? (!bwd_done && m_q == MonthJan && y_q == YearBits'(YearMin))
                          : (!fwd_done && m_q == MonthDec && y_q == YearBits'(YearMax));

  assign sts_o.reduce_last = (sh_q == '0);
  assign sts_o.start_bad   = start_bad;
  assign sts_o.walk_end    = (cmd_q ? bwd_done : fwd_done) || walk_err;
  assign sts_o.out_free    = !out_valid_q || rsp_ready_i;

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= req_i.cmd;
      y0_q   <= req_i.start_year;
      m0_q   <= req_i.start_month;
      d0_q   <= req_i.start_day;
      y_q    <= req_i.start_year;
      m_q    <= req_i.start_month;
      r_q    <= req_i.start_year;
      sh_q   <= ShStart;
      d_q    <= req_i.cmd ? (DW'(req_i.start_day) - DW'(off_n))
                          : (DW'(req_i.start_day) + DW'(off_n));
    end
    if (cmd_i.reduce) begin
      if (r_q >= cand) begin
        r_q <= r_q - cand;
      end
      sh_q <= sh_q - ShBits'(1);
    end
    if (cmd_i.check) begin
      status_q <= start_bad ? StatusBadStart : StatusOk;
    end
    if (cmd_i.walk) begin
      if (walk_err) begin
        status_q <= StatusRange;
      end else if (!cmd_q && !fwd_done) begin
        d_q <= d_q - len_cur_s;
        if (m_q == MonthDec) begin
          m_q <= MonthJan;
          y_q <= y_q + YearBits'(1);
          r_q <= YearBits'(r_next);
        end else begin
          m_q <= m_q + MonthBits'(1);
        end
      end else if (cmd_q && !bwd_done) begin
        d_q <= d_q + len_prev_s;
        m_q <= m_prev;
        r_q <= YearBits'(r_back);
        if (m_q == MonthJan) begin
          y_q <= y_q - YearBits'(1);
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.status <= status_q;
      if (status_q == StatusOk) begin
        out_q.result_year  <= y_q;
        out_q.result_month <= m_q;
        out_q.result_day   <= d_q[DayBits-1:0];
      end else begin
        out_q.result_year  <= y0_q;
        out_q.result_month <= m0_q;
        out_q.result_day   <= d0_q;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
